[hw/rtl/assert_macros.svh]
// assertion helpers, included by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

[hw/rtl/utrq_pkg.sv]
package utrq_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    // wide enough for pointer sums and for the 9-bit length and offset fields
    localparam int CMP_W       = ((PTR_W > 9) ? PTR_W : 9) + 2;

    // result queue between front and back
    localparam int QQ_DEPTH    = 4;
    localparam int QQ_AW       = $clog2(QQ_DEPTH);
    localparam int LVL_W       = $clog2(QQ_DEPTH + 1);

    localparam logic [2:0] F_PUSH  = 3'd0;
    localparam logic [2:0] F_START = 3'd1;
    localparam logic [2:0] F_DONE  = 3'd2;
    localparam logic [2:0] F_ABORT = 3'd3;
    localparam logic [2:0] F_READ  = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic        accepted;
        logic [8:0]  chunk_start;
        logic [8:0]  chunk_len;
        logic        started;
        logic [7:0]  out_byte;
        logic        busy_flag;
        logic [8:0]  fill;
        logic [31:0] drop_count;
    } t_res;

endpackage

[hw/rtl/utrq_ram.sv]
module utrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/utrq_front.sv]
module utrq_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [2:0]                i_func,
    input  logic [7:0]                i_data,
    input  logic [8:0]                i_burst_len,
    input  logic                      i_burst_first,
    input  logic                      i_burst_last,
    input  logic                      i_uart_accepts,
    input  logic [8:0]                i_offset,
    input  logic [utrq_pkg::LVL_W-1:0] i_level,
    output logic                      o_res_valid,
    output utrq_pkg::t_res            o_res
);

    localparam int CW = utrq_pkg::CMP_W;
    localparam int PW = utrq_pkg::PTR_W;

    utrq_pkg::t_ptr r_head, n_head;
    utrq_pkg::t_ptr r_tail, n_tail;
    utrq_pkg::t_ptr r_wptr, n_wptr;
    utrq_pkg::t_ptr r_inflight, n_inflight;
    logic           r_rej, n_rej;
    logic           r_open, n_open;
    logic [8:0]     r_room, n_room;
    logic           r_busy, n_busy;
    logic [31:0]    r_drop, n_drop;

    logic           r_job_valid;
    logic           r_job_rd;
    utrq_pkg::t_res r_job;
    utrq_pkg::t_res w_job;

    logic           w_acc;
    logic           w_ok, w_started, w_rd;
    logic           w_we, w_re;
    utrq_pkg::t_ptr w_waddr, w_raddr;
    logic [CW-1:0]  w_used, w_free, w_rsum, w_dsum, w_used_next;
    logic [7:0]     w_rdata;

    assign full  = !i_rst_n
                 || ((i_level + utrq_pkg::LVL_W'(r_job_valid))
                     >= utrq_pkg::LVL_W'(utrq_pkg::QUEUE_DEPTH > 0 ? utrq_pkg::QQ_DEPTH : 1));
    assign w_acc = push && !full;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_wptr     = r_wptr;
        n_inflight = r_inflight;
        n_rej      = r_rej;
        n_open     = r_open;
        n_room     = r_room;
        n_busy     = r_busy;
        n_drop     = r_drop;
        w_ok       = 1'b0;
        w_started  = 1'b0;
        w_rd       = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = r_wptr;
        w_raddr    = r_tail;

        w_used = (r_head >= r_tail) ? CW'(r_head) - CW'(r_tail)
                                    : CW'(r_head) + CW'(utrq_pkg::QUEUE_DEPTH) - CW'(r_tail);
        w_free = CW'(utrq_pkg::QUEUE_DEPTH - 1) - w_used;

        w_rsum = CW'(r_tail) + CW'(i_offset);
        if (w_rsum >= CW'(utrq_pkg::QUEUE_DEPTH)) begin
            w_rsum = w_rsum - CW'(utrq_pkg::QUEUE_DEPTH);
        end
        w_dsum = CW'(r_tail) + CW'(r_inflight);
        if (w_dsum >= CW'(utrq_pkg::QUEUE_DEPTH)) begin
            w_dsum = w_dsum - CW'(utrq_pkg::QUEUE_DEPTH);
        end

        case (i_func)
            utrq_pkg::F_PUSH: begin
                if (i_burst_first) begin
                    // a new burst drops whatever the open one had not committed
                    n_open = 1'b1;
                    n_wptr = r_head;
                    n_rej  = CW'(i_burst_len) > w_free;
                    n_room = n_rej ? 9'd0 : i_burst_len;
                    if (n_rej) begin
                        n_drop = r_drop + 32'd1;
                    end
                end
                if (n_open) begin
                    if (!n_rej && (n_room != 9'd0)) begin
                        w_we    = w_acc;
                        w_waddr = n_wptr;
                        n_wptr  = (n_wptr == PW'(utrq_pkg::QUEUE_DEPTH - 1))
                                ? '0 : n_wptr + PW'(1);
                        n_room  = n_room - 9'd1;
                        w_ok    = 1'b1;
                    end
                    if (i_burst_last) begin
                        if (!n_rej) begin
                            n_head = n_wptr;
                        end
                        n_open = 1'b0;
                        n_rej  = 1'b0;
                        n_room = 9'd0;
                    end
                end
            end
            utrq_pkg::F_START: begin
                if (!r_busy && (r_head != r_tail)) begin
                    // stop at the end of the store when head has wrapped
                    n_inflight = (r_head > r_tail) ? r_head - r_tail
                               : PW'(CW'(utrq_pkg::QUEUE_DEPTH) - CW'(r_tail));
                    n_busy     = i_uart_accepts;
                    w_started  = i_uart_accepts;
                    w_ok       = i_uart_accepts;
                end
            end
            utrq_pkg::F_DONE: begin
                if (r_busy) begin
                    n_tail = PW'(w_dsum);
                    n_busy = 1'b0;
                    w_ok   = 1'b1;
                end
            end
            utrq_pkg::F_ABORT: begin
                if (r_busy) begin
                    n_busy = 1'b0;
                    w_ok   = 1'b1;
                end
            end
            utrq_pkg::F_READ: begin
                if (r_busy && (CW'(i_offset) < CW'(r_inflight))) begin
                    w_rd    = 1'b1;
                    w_re    = w_acc;
                    w_raddr = PW'(w_rsum);
                    w_ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        w_used_next = (n_head >= n_tail) ? CW'(n_head) - CW'(n_tail)
                    : CW'(n_head) + CW'(utrq_pkg::QUEUE_DEPTH) - CW'(n_tail);

        w_job.accepted    = w_ok;
        w_job.chunk_start = 9'(n_tail);
        w_job.chunk_len   = 9'(n_inflight);
        w_job.started     = w_started;
        w_job.out_byte    = 8'd0;
        w_job.busy_flag   = n_busy;
        w_job.fill        = 9'(w_used_next);
        w_job.drop_count  = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_wptr      <= '0;
            r_inflight  <= '0;
            r_rej       <= 1'b0;
            r_open      <= 1'b0;
            r_room      <= 9'd0;
            r_busy      <= 1'b0;
            r_drop      <= 32'd0;
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= w_acc;
            if (w_acc) begin
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_wptr     <= n_wptr;
                r_inflight <= n_inflight;
                r_rej      <= n_rej;
                r_open     <= n_open;
                r_room     <= n_room;
                r_busy     <= n_busy;
                r_drop     <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job    <= w_job;
            r_job_rd <= w_rd;
        end
    end

    utrq_ram #(
        .WIDTH (8),
        .DEPTH (utrq_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // store data lands in the cycle after the read, alongside the job
    always_comb begin
        o_res          = r_job;
        o_res.out_byte = r_job_rd ? w_rdata : 8'd0;
    end

    assign o_res_valid = r_job_valid;

endmodule

[hw/rtl/utrq_back.sv]
module utrq_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_res_valid,
    input  utrq_pkg::t_res             i_res,
    output logic [utrq_pkg::LVL_W-1:0] o_level,
    output logic                       empty,
    input  logic                       pop,
    output utrq_pkg::t_res             o_res
);

    utrq_pkg::t_res                 r_mem [utrq_pkg::QQ_DEPTH];
    logic [utrq_pkg::QQ_AW-1:0]     r_wp;
    logic [utrq_pkg::QQ_AW-1:0]     r_rp;
    logic [utrq_pkg::LVL_W-1:0]     r_level;
    logic                           w_pop;

    assign w_pop = pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_res_valid) begin
                r_wp <= (r_wp == utrq_pkg::QQ_AW'(utrq_pkg::QQ_DEPTH - 1))
                      ? '0 : r_wp + utrq_pkg::QQ_AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == utrq_pkg::QQ_AW'(utrq_pkg::QQ_DEPTH - 1))
                      ? '0 : r_rp + utrq_pkg::QQ_AW'(1);
            end
            if (i_res_valid && !w_pop) begin
                r_level <= r_level + utrq_pkg::LVL_W'(1);
            end else if (!i_res_valid && w_pop) begin
                r_level <= r_level - utrq_pkg::LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_mem[r_wp] <= i_res;
        end
    end

    assign o_level = r_level;
    assign empty   = (r_level == '0);
    assign o_res   = r_mem[r_rp];

endmodule

[hw/rtl/uart_tx_ring_queue_core.sv]
// Transmit ring queue for a UART: one transaction a cycle is taken while full is low, and
// each one gives exactly one result. On accepting, the front updates its state, starts any
// store read and registers the result, which is then written into the four-entry result
// queue; empty drops and the result can be popped once that write is done. full is high
// in reset and otherwise rises only when that result queue, counting the result still in
// the front, has no room; popping results keeps the rate at one per cycle.
`include "assert_macros.svh"

module uart_tx_ring_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_data,
    input  logic [8:0]  i_burst_len,
    input  logic        i_burst_first,
    input  logic        i_burst_last,
    input  logic        i_uart_accepts,
    input  logic [8:0]  i_offset,
    output logic        empty,
    input  logic        pop,
    output logic        o_accepted,
    output logic [8:0]  o_chunk_start,
    output logic [8:0]  o_chunk_len,
    output logic        o_started,
    output logic [7:0]  o_out_byte,
    output logic        o_busy_flag,
    output logic [8:0]  o_fill,
    output logic [31:0] o_drop_count
);

    logic [utrq_pkg::LVL_W-1:0] w_level;
    logic                       w_res_valid;
    utrq_pkg::t_res             w_res;
    utrq_pkg::t_res             w_out;

    utrq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_data         (i_data),
        .i_burst_len    (i_burst_len),
        .i_burst_first  (i_burst_first),
        .i_burst_last   (i_burst_last),
        .i_uart_accepts (i_uart_accepts),
        .i_offset       (i_offset),
        .i_level        (w_level),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    utrq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_level     (w_level),
        .empty       (empty),
        .pop         (pop),
        .o_res       (w_out)
    );

    assign o_accepted    = w_out.accepted;
    assign o_chunk_start = w_out.chunk_start;
    assign o_chunk_len   = w_out.chunk_len;
    assign o_started     = w_out.started;
    assign o_out_byte    = w_out.out_byte;
    assign o_busy_flag   = w_out.busy_flag;
    assign o_fill        = w_out.fill;
    assign o_drop_count  = w_out.drop_count;

    // every accepted transaction reaches the result queue on the next edge
    `ASSERT_NEXT(a_job_follows, i_clk, i_rst_n, push && !full, w_res_valid, "job lost")

    // the result queue never overruns
    `ASSERT_IMPLIES(a_no_overrun, i_clk, i_rst_n, w_res_valid,
        w_level < utrq_pkg::LVL_W'(utrq_pkg::QQ_DEPTH), "result queue overrun")

    // a launched chunk leaves the transmitter busy
    `ASSERT_IMPLIES(a_start_busy, i_clk, i_rst_n, w_res_valid && w_res.started,
        w_res.busy_flag && w_res.accepted, "start without busy")

    // popping the last result with nothing arriving drains the queue
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        pop && !empty && (w_level == utrq_pkg::LVL_W'(1)) && !w_res_valid, empty,
        "queue not drained")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// one request towards the ring queue, every field at its port width
typedef struct {
    logic [2:0] func;
    logic [7:0] data;
    logic [8:0] burst_len;
    logic       opens;
    logic       closes;
    logic       takes;
    logic [8:0] offset;
} t_txq_op;

class txq_scoreboard;
    logic [7:0]  ring_copy [utrq_pkg::QUEUE_DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    int unsigned wr_idx;
    int unsigned room_left;
    int unsigned flight_len;
    bit          rejecting;
    bit          burst_open;
    bit          tx_owned;
    logic [31:0] drops;
    utrq_pkg::t_res status_q [$];
    int unsigned errors;

    function new();
        foreach (ring_copy[i]) ring_copy[i] = 8'h00;
        head_idx   = 0;
        tail_idx   = 0;
        wr_idx     = 0;
        room_left  = 0;
        flight_len = 0;
        rejecting  = 0;
        burst_open = 0;
        tx_owned   = 0;
        drops      = 32'd0;
        errors     = 0;
    endfunction

    function int unsigned bytes_held();
        return (head_idx + utrq_pkg::QUEUE_DEPTH - tail_idx) % utrq_pkg::QUEUE_DEPTH;
    endfunction

    function int unsigned pending();
        return status_q.size();
    endfunction

    // works out the status a transaction leaves behind and queues it
    function void note_op(t_txq_op op);
        utrq_pkg::t_res st;
        bit          ok;
        bit          launched;
        logic [7:0]  rd_byte;
        int unsigned rd_idx;
        ok       = 0;
        launched = 0;
        rd_byte  = 8'h00;
        case (op.func)
            utrq_pkg::F_PUSH: begin
                if (op.opens) begin
                    burst_open = 1;
                    wr_idx     = head_idx;
                    rejecting  = op.burst_len > (utrq_pkg::QUEUE_DEPTH - 1 - bytes_held());
                    room_left  = rejecting ? 0 : 32'(op.burst_len);
                    if (rejecting) drops = drops + 32'd1;
                end
                if (burst_open) begin
                    if (!rejecting && room_left > 0) begin
                        ring_copy[wr_idx[8:0]] = op.data;
                        wr_idx = (wr_idx + 1) % utrq_pkg::QUEUE_DEPTH;
                        room_left--;
                        ok = 1;
                    end
                    if (op.closes) begin
                        if (!rejecting) head_idx = wr_idx;
                        burst_open = 0;
                        rejecting  = 0;
                        room_left  = 0;
                    end
                end
            end
            utrq_pkg::F_START: begin
                if (!tx_owned && head_idx != tail_idx) begin
                    // a wrapped queue goes out in two chunks, the first up to the store end
                    flight_len = (head_idx > tail_idx) ? head_idx - tail_idx
                                                       : utrq_pkg::QUEUE_DEPTH - tail_idx;
                    tx_owned   = op.takes;
                    launched   = op.takes;
                    ok         = op.takes;
                end
            end
            utrq_pkg::F_DONE: begin
                if (tx_owned) begin
                    tail_idx = (tail_idx + flight_len) % utrq_pkg::QUEUE_DEPTH;
                    tx_owned = 0;
                    ok       = 1;
                end
            end
            utrq_pkg::F_ABORT: begin
                if (tx_owned) begin
                    tx_owned = 0;
                    ok       = 1;
                end
            end
            utrq_pkg::F_READ: begin
                if (tx_owned && op.offset < flight_len) begin
                    rd_idx  = (tail_idx + 32'(op.offset)) % utrq_pkg::QUEUE_DEPTH;
                    rd_byte = ring_copy[rd_idx[8:0]];
                    ok      = 1;
                end
            end
            default: begin
            end
        endcase
        st.accepted    = ok;
        st.chunk_start = tail_idx[8:0];
        st.chunk_len   = flight_len[8:0];
        st.started     = launched;
        st.out_byte    = rd_byte;
        st.busy_flag   = tx_owned;
        st.fill        = 9'(bytes_held());
        st.drop_count  = drops;
        status_q.push_back(st);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_status(utrq_pkg::t_res got);
        utrq_pkg::t_res want;
        if (status_q.size() == 0) begin
            $error("status popped with no transaction outstanding");
            errors++;
            return;
        end
        want = status_q.pop_front();
        cmp_field("accepted", 32'(want.accepted), 32'(got.accepted));
        cmp_field("chunk_start", 32'(want.chunk_start), 32'(got.chunk_start));
        cmp_field("chunk_len", 32'(want.chunk_len), 32'(got.chunk_len));
        cmp_field("started", 32'(want.started), 32'(got.started));
        cmp_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
        cmp_field("busy_flag", 32'(want.busy_flag), 32'(got.busy_flag));
        cmp_field("fill", 32'(want.fill), 32'(got.fill));
        cmp_field("drop_count", want.drop_count, got.drop_count);
    endfunction

    function void flag_leftovers();
        if (status_q.size() != 0) begin
            $error("%0d status entries never arrived", status_q.size());
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [2:0] F_SPARE    = 3'd7;
    localparam int         N_ITEMS    = 1500;
    localparam int         CALM_AFTER = 1300;
    localparam int         HOLD_AT    = 400;
    localparam int         HOLD_LEN   = 300;
    localparam int         DRAIN_AT   = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_func = utrq_pkg::F_PUSH;
    logic [7:0]  i_data = 8'h00;
    logic [8:0]  i_burst_len = 9'd0;
    logic        i_burst_first = 1'b0;
    logic        i_burst_last = 1'b0;
    logic        i_uart_accepts = 1'b0;
    logic [8:0]  i_offset = 9'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_accepted;
    logic [8:0]  o_chunk_start;
    logic [8:0]  o_chunk_len;
    logic        o_started;
    logic [7:0]  o_out_byte;
    logic        o_busy_flag;
    logic [8:0]  o_fill;
    logic [31:0] o_drop_count;

    txq_scoreboard sb;
    int unsigned   n_sent = 0;
    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_idle_pct = 0;
    bit            calm = 0;
    bit            hold_done = 0;

    uart_tx_ring_queue_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_data         (i_data),
        .i_burst_len    (i_burst_len),
        .i_burst_first  (i_burst_first),
        .i_burst_last   (i_burst_last),
        .i_uart_accepts (i_uart_accepts),
        .i_offset       (i_offset),
        .empty          (empty),
        .pop            (pop),
        .o_accepted     (o_accepted),
        .o_chunk_start  (o_chunk_start),
        .o_chunk_len    (o_chunk_len),
        .o_started      (o_started),
        .o_out_byte     (o_out_byte),
        .o_busy_flag    (o_busy_flag),
        .o_fill         (o_fill),
        .o_drop_count   (o_drop_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("uart_tx_ring_queue_core test failed");
        $finish;
    end

    // handshake signals only move at rising edges, so the falling edge sees settled values
    always @(negedge i_clk) begin
        t_txq_op        op;
        utrq_pkg::t_res got;
        if (i_rst_n && push && !full) begin
            op.func      = i_func;
            op.data      = i_data;
            op.burst_len = i_burst_len;
            op.opens     = i_burst_first;
            op.closes    = i_burst_last;
            op.takes     = i_uart_accepts;
            op.offset    = i_offset;
            sb.note_op(op);
        end
        if (i_rst_n && pop && !empty) begin
            got.accepted    = o_accepted;
            got.chunk_start = o_chunk_start;
            got.chunk_len   = o_chunk_len;
            got.started     = o_started;
            got.out_byte    = o_out_byte;
            got.busy_flag   = o_busy_flag;
            got.fill        = o_fill;
            got.drop_count  = o_drop_count;
            sb.check_status(got);
        end
    end

    function automatic t_txq_op rand_op(logic [2:0] f);
        t_txq_op op;
        op.func      = f;
        op.data      = 8'($urandom_range(0, 255));
        op.burst_len = 9'($urandom_range(0, 511));
        op.opens     = 1'($urandom_range(0, 1));
        op.closes    = 1'($urandom_range(0, 1));
        op.takes     = 1'($urandom_range(0, 1));
        op.offset    = 9'($urandom_range(0, 511));
        return op;
    endfunction

    task automatic send(t_txq_op op);
        bit took;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= op.func;
        i_data         <= op.data;
        i_burst_len    <= op.burst_len;
        i_burst_first  <= op.opens;
        i_burst_last   <= op.closes;
        i_uart_accepts <= op.takes;
        i_offset       <= op.offset;
        do begin
            @(negedge i_clk);
            took = !full;
            @(posedge i_clk);
        end while (!took);
        n_sent++;
        calm = (n_sent >= CALM_AFTER);
    endtask

    // burst of n_bytes pushes, declared length on the opening byte only
    task automatic send_burst(int unsigned n_bytes, int unsigned declared, bit closed);
        t_txq_op op;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            op        = rand_op(utrq_pkg::F_PUSH);
            op.opens  = (i == 0);
            op.closes = closed && (i == n_bytes - 1);
            if (i == 0) op.burst_len = 9'(declared);
            send(op);
        end
    endtask

    task automatic send_read(bit in_range);
        t_txq_op op;
        op = rand_op(utrq_pkg::F_READ);
        if (in_range && sb.tx_owned && sb.flight_len > 0)
            op.offset = 9'($urandom_range(0, sb.flight_len - 1));
        send(op);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic directed_part();
        t_txq_op    op;
        logic [7:0] edge_bytes [3];
        edge_bytes[0] = 8'h00;
        edge_bytes[1] = 8'hFF;
        edge_bytes[2] = 8'h5A;
        // stray byte outside any burst
        op = rand_op(utrq_pkg::F_PUSH);
        op.opens  = 1'b0;
        op.closes = 1'b1;
        send(op);
        send(rand_op(utrq_pkg::F_DONE));
        send(rand_op(utrq_pkg::F_READ));
        send(rand_op(utrq_pkg::F_START));
        send(rand_op(F_SPARE));
        send_burst(1, 0, 1'b1);
        foreach (edge_bytes[i]) begin
            op = rand_op(utrq_pkg::F_PUSH);
            op.data   = edge_bytes[i];
            op.opens  = (i == 0);
            op.closes = (i == 2);
            if (i == 0) op.burst_len = 9'd3;
            send(op);
        end
        send_burst(2, 511, 1'b1);
        send_burst(3, 2, 1'b1);
        send_burst(1, 5, 1'b1);
        // opening byte while a burst is still open abandons it
        send_burst(1, 4, 1'b0);
        send_burst(2, 2, 1'b1);
        op = rand_op(utrq_pkg::F_START);
        op.takes = 1'b0;
        send(op);
        op.takes = 1'b1;
        send(op);
        send(op);
        op = rand_op(utrq_pkg::F_READ);
        op.offset = 9'd0;
        send(op);
        op.offset = 9'(sb.flight_len);
        send(op);
        op.offset = 9'h1FF;
        send(op);
        send(rand_op(utrq_pkg::F_ABORT));
        op = rand_op(utrq_pkg::F_START);
        op.takes = 1'b1;
        send(op);
        send(rand_op(utrq_pkg::F_DONE));
    endtask

    task automatic random_part();
        int unsigned pick;
        int unsigned len;
        int unsigned n_reads;
        bit          drained = 0;
        t_txq_op     op;
        while (n_sent < N_ITEMS) begin
            if (!drained && n_sent >= DRAIN_AT) begin
                hold_until_drained();
                drained = 1;
            end
            tx_idle_pct = $urandom_range(0, 3) * 8;
            pick        = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 32))
                    0:       len = $urandom_range(81, 511);
                    1, 2, 3: len = $urandom_range(17, 80);
                    default: len = $urandom_range(1, 16);
                endcase
                send_burst(len, len, 1'b1);
            end else if (pick < 55) begin
                len = $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0:       send_burst(len, $urandom_range(0, len - 1), 1'b1);
                    1:       send_burst(len, len + $urandom_range(1, 20), 1'b1);
                    2:       send_burst(len, len, 1'b0);
                    default: send_burst(1, 0, 1'b1);
                endcase
            end else if (pick < 85) begin
                op = rand_op(utrq_pkg::F_START);
                op.takes = ($urandom_range(0, 6) != 0);
                send(op);
                n_reads = $urandom_range(0, 6);
                repeat (n_reads) send_read($urandom_range(0, 4) != 0);
                send(rand_op(($urandom_range(0, 3) == 0) ? utrq_pkg::F_ABORT
                                                         : utrq_pkg::F_DONE));
            end else begin
                send(rand_op(3'($urandom_range(0, 7))));
            end
        end
    endtask

    // result side: short random stalls, one long hold-off so full has to rise
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_idle_pct = $urandom_range(0, 3) * 10;
            if (!hold_done && n_sent >= HOLD_AT) begin
                pop <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1;
            end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned guard;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_part();
        hold_until_drained();
        random_part();
        push <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.errors == 0) begin
            $display("uart_tx_ring_queue_core test passed");
        end else begin
            $display("uart_tx_ring_queue_core test failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/utrq_pkg.sv
hw/rtl/utrq_ram.sv
hw/rtl/utrq_front.sv
hw/rtl/utrq_back.sv
hw/rtl/uart_tx_ring_queue_core.sv
tb/tb_top.sv
